// File: rtl/stp_pkg.sv
package stp_pkg;

    // Block limits.
    localparam int MAX_LENGTH = 512;
    localparam int ADDR_BITS  = 24;
    localparam int LEN_W      = 10;
    localparam int CAP_W      = ADDR_BITS + 1;

    // Effective register ranges.
    localparam logic [4:0] CAP_LOG2_MIN  = 5'd7;
    localparam logic [4:0] CAP_LOG2_MAX  = 5'(ADDR_BITS);
    localparam logic [3:0] PAGE_LOG2_MIN = 4'd4;
    localparam logic [3:0] PAGE_LOG2_MAX = 4'd9;

    // Register reset values.
    localparam logic [4:0] CAP_LOG2_RST  = 5'd15;
    localparam logic [3:0] PAGE_LOG2_RST = 4'd6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CAPACITY  = 2'd0;
    localparam logic [1:0] CFG_PAGE_SIZE = 2'd1;

    // SPI command bytes and the folded address bit.
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_WRITE = 8'h02;
    localparam logic [7:0] OP_A8    = 8'h08;

    // Request kinds on the input side.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_REJECT = 2'd0,
        KIND_READ   = 2'd1,
        KIND_WRITE  = 2'd2
    } t_kind;

    // One classified request, handed from the front to the back.
    typedef struct packed {
        t_kind                  kind;
        logic [ADDR_BITS-1:0]   addr;
        logic [LEN_W-1:0]       total;
        logic [1:0]             nab;
        logic                   cap512;
        logic [3:0]             plog;
    } t_plan;

endpackage

// File: rtl/stp_front.sv
module stp_front import stp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [1:0]            i_cfg_index,
    input  logic [4:0]            i_cfg_data,
    input  logic                  i_cmd,
    input  logic [ADDR_BITS-1:0]  i_addr,
    input  logic [LEN_W-1:0]      i_len,
    output t_plan                 o_plan
);

    logic [4:0]       r_cap_log2;
    logic [3:0]       r_page_log2;
    logic [4:0]       cap_log2;
    logic [3:0]       page_log2;
    logic [CAP_W-1:0] cap;
    logic [CAP_W-1:0] end_addr;
    logic [CAP_W-1:0] tail;
    logic [LEN_W-1:0] len_sat;
    logic             reject;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_log2  <= CAP_LOG2_RST;
            r_page_log2 <= PAGE_LOG2_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CAPACITY:  r_cap_log2  <= i_cfg_data;
                CFG_PAGE_SIZE: r_page_log2 <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Saturate the registers into their legal ranges.
    always_comb begin
        cap_log2 = r_cap_log2;
        if (cap_log2 < CAP_LOG2_MIN) cap_log2 = CAP_LOG2_MIN;
        if (cap_log2 > CAP_LOG2_MAX) cap_log2 = CAP_LOG2_MAX;
        page_log2 = r_page_log2;
        if (page_log2 < PAGE_LOG2_MIN) page_log2 = PAGE_LOG2_MIN;
        if (page_log2 > PAGE_LOG2_MAX) page_log2 = PAGE_LOG2_MAX;
    end

    // Classify the request and clip its length to the end of the part.
    always_comb begin
        cap      = CAP_W'(1) << cap_log2;
        len_sat  = (i_len > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : i_len;
        reject   = ({1'b0, i_addr} >= cap) || (i_len == '0);
        end_addr = {1'b0, i_addr} + CAP_W'(len_sat);
        tail     = cap - {1'b0, i_addr};

        o_plan.addr   = i_addr;
        o_plan.total  = (end_addr <= cap) ? len_sat : tail[LEN_W-1:0];
        o_plan.cap512 = (cap_log2 == 5'd9);
        o_plan.plog   = page_log2;
        if (cap_log2 <= 5'd9)       o_plan.nab = 2'd1;
        else if (cap_log2 <= 5'd16) o_plan.nab = 2'd2;
        else                        o_plan.nab = 2'd3;

        if (reject)                   o_plan.kind = KIND_REJECT;
        else if (i_cmd == CMD_WRITE)  o_plan.kind = KIND_WRITE;
        else                          o_plan.kind = KIND_READ;
    end

endmodule

// File: rtl/stp_queue.sv
module stp_queue import stp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_plan  i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_plan  o_data
);

    t_plan      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    // Storage of the two entries.
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: rtl/stp_back.sv
module stp_back import stp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_plan                 i_plan,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_kind                 o_kind,
    output logic [7:0]            o_opcode,
    output logic [1:0]            o_nab,
    output logic [ADDR_BITS-1:0]  o_addr,
    output logic [LEN_W-1:0]      o_count,
    output logic                  o_last
);

    logic                  r_busy;
    t_plan                 r_plan;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [LEN_W-1:0]      r_rem;
    logic                  r_ovalid;
    t_kind                 r_okind;
    logic [7:0]            r_oop;
    logic [1:0]            r_onab;
    logic [ADDR_BITS-1:0]  r_oaddr;
    logic [LEN_W-1:0]      r_ocnt;
    logic                  r_olast;

    logic                  emit;
    logic [LEN_W-1:0]      page;
    logic [LEN_W-1:0]      off;
    logic [LEN_W-1:0]      room;
    logic [LEN_W-1:0]      n;
    logic                  fin;
    logic [ADDR_BITS-1:0]  amask;
    logic [7:0]            op;

    assign o_pop = !r_busy && i_valid;
    assign emit  = r_busy && (!r_ovalid || i_ready);

    // For a write, split the remaining bytes at the next page boundary.
    always_comb begin
        page = LEN_W'(1) << r_plan.plog;
        off  = r_addr[LEN_W-1:0] & (page - LEN_W'(1));
        room = page - off;
        if (r_plan.kind == KIND_WRITE) begin
            fin = (r_rem <= room);
            n   = fin ? r_rem : room;
        end else begin
            fin = 1'b1;
            n   = r_rem;
        end
        case (r_plan.nab)
            2'd1:    amask = ADDR_BITS'(24'h0000FF);
            2'd2:    amask = ADDR_BITS'(24'h00FFFF);
            default: amask = {ADDR_BITS{1'b1}};
        endcase
        op = (r_plan.kind == KIND_WRITE) ? OP_WRITE : OP_READ;
        if (r_plan.cap512 && r_addr[8]) op = op | OP_A8;
    end

    // Request sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (emit && fin) begin
            r_busy <= 1'b0;
        end
    end

    // Working address and remaining length.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_plan <= i_plan;
            r_addr <= i_plan.addr;
            r_rem  <= i_plan.total;
        end else if (emit) begin
            r_addr <= r_addr + ADDR_BITS'(n);
            r_rem  <= r_rem - n;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_okind <= r_plan.kind;
            r_olast <= fin;
            if (r_plan.kind == KIND_REJECT) begin
                r_oop   <= '0;
                r_onab  <= '0;
                r_oaddr <= '0;
                r_ocnt  <= '0;
            end else begin
                r_oop   <= op;
                r_onab  <= r_plan.nab;
                r_oaddr <= r_addr & amask;
                r_ocnt  <= n;
            end
        end
    end

    assign o_valid  = r_ovalid;
    assign o_kind   = r_okind;
    assign o_opcode = r_oop;
    assign o_nab    = r_onab;
    assign o_addr   = r_oaddr;
    assign o_count  = r_ocnt;
    assign o_last   = r_olast;

endmodule

// File: rtl/spi_eeprom_transfer_planner.sv
// Serial EEPROM transfer planner. Each request on the slave stream (read or
// write, start address, length) is checked against the configured capacity
// and turned into SPI transaction descriptors on the master stream: one
// reject result for an address past the end or a zero length, one READ
// descriptor for a read, and one WRITE descriptor per page touched for a
// write, with tlast on the final descriptor of the request. The front stage
// classifies a request in the cycle it is taken and parks it in a two-entry
// queue; the back sequencer first loads a request and then emits one
// descriptor per cycle unless the receiver stalls it. Configuration
// writes (index 0 capacity_log2, index 1 page_size_log2) are taken every
// cycle and must only be issued while the block is idle.
module spi_eeprom_transfer_planner import stp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write channel.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [4:0]   i_cfg_data,
    // Request stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // start_address[23:0], length[33:24], zero fill
    input  logic         s_tuser,   // cmd[0]
    // Descriptor stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // opcode_byte[7:0], address_bytes[9:8],
                                    // address_field[33:10], byte_count[43:34], zero fill
    output logic [1:0]   m_tuser,   // kind[1:0]
    output logic         m_tlast
);

    t_plan                 f_plan;
    t_plan                 q_plan;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;
    t_kind                 b_kind;
    logic [7:0]            b_op;
    logic [1:0]            b_nab;
    logic [ADDR_BITS-1:0]  b_addr;
    logic [LEN_W-1:0]      b_cnt;

    assign o_cfg_ready = 1'b1;
    assign s_tready    = !q_full;

    // Request classification and configuration registers.
    stp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (s_tuser),
        .i_addr      (s_tdata[23:0]),
        .i_len       (s_tdata[33:24]),
        .o_plan      (f_plan)
    );

    // Queue between classification and sequencing.
    stp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_tvalid),
        .i_data  (f_plan),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_plan)
    );

    // Page sequencer with output register.
    stp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_plan   (q_plan),
        .o_pop    (q_pop),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_kind   (b_kind),
        .o_opcode (b_op),
        .o_nab    (b_nab),
        .o_addr   (b_addr),
        .o_count  (b_cnt),
        .o_last   (m_tlast)
    );

    assign m_tdata = {4'b0000, b_cnt, b_addr, b_nab, b_op};
    assign m_tuser = b_kind;

endmodule

// File: tb/spi_eeprom_transfer_planner_tb.sv
module spi_eeprom_transfer_planner_tb;
    import stp_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_REPORTS  = 100;

    // Register indexes past the two real registers; writes to them must be ignored.
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    // One SPI transaction descriptor as seen on the master stream.
    typedef struct {
        t_kind       kind;
        logic [7:0]  opcode;
        logic [1:0]  addr_bytes;
        logic [23:0] addr;
        logic [9:0]  count;
        logic        last;
    } t_descriptor;

    // Receiver back-pressure patterns.
    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_SPARSE,
        STALL_PERIODIC
    } t_stall;

    // Plans the descriptors of every accepted request and checks what comes out.
    class planner_scoreboard;
        t_descriptor descriptor_q[$];
        logic [4:0]  cap_log2  = CAP_LOG2_RST;
        logic [3:0]  page_log2 = PAGE_LOG2_RST;
        int n_errors  = 0;
        int n_results = 0;
        int n_reads   = 0;
        int n_writes  = 0;
        int n_rejects = 0;

        task report(string msg);
            if (n_errors < MAX_REPORTS)
                $display("ERROR: %s", msg);
            n_errors++;
        endtask

        function void write_reg(logic [1:0] index, logic [4:0] value);
            case (index)
                CFG_CAPACITY:  cap_log2  = value;
                CFG_PAGE_SIZE: page_log2 = value[3:0];
                default: ;
            endcase
        endfunction

        // Register values outside the supported range saturate.
        function longint capacity_bytes();
            logic [4:0] c;
            c = cap_log2;
            if (c < CAP_LOG2_MIN) c = CAP_LOG2_MIN;
            if (c > CAP_LOG2_MAX) c = CAP_LOG2_MAX;
            return longint'(1) << c;
        endfunction

        function longint page_bytes();
            logic [3:0] p;
            p = page_log2;
            if (p < PAGE_LOG2_MIN) p = PAGE_LOG2_MIN;
            if (p > PAGE_LOG2_MAX) p = PAGE_LOG2_MAX;
            return longint'(1) << p;
        endfunction

        function void note_request(logic cmd, logic [23:0] start, logic [9:0] req_len);
            longint cap, page, len, total, done, a, off, n;
            int nab;
            logic [23:0] amask;
            t_descriptor d;
            cap  = capacity_bytes();
            page = page_bytes();
            len  = (req_len > MAX_LENGTH) ? MAX_LENGTH : req_len;

            // Start past the end of the part or an empty request.
            if (start >= cap || len == 0) begin
                d.kind = KIND_REJECT;
                d.opcode = 8'h00;
                d.addr_bytes = 2'd0;
                d.addr = 24'h0;
                d.count = 10'd0;
                d.last = 1'b1;
                descriptor_q.push_back(d);
                n_rejects++;
                return;
            end

            // Requests running off the end are clipped.
            total = (start + len <= cap) ? len : cap - start;
            nab   = (cap <= 512) ? 1 : (cap <= 65536) ? 2 : 3;
            amask = (nab == 3) ? 24'hFFFFFF : 24'((longint'(1) << (8 * nab)) - 1);

            if (cmd == CMD_READ) begin
                d.kind = KIND_READ;
                d.opcode = OP_READ | ((cap == 512 && start[8]) ? OP_A8 : 8'h00);
                d.addr_bytes = 2'(nab);
                d.addr = start & amask;
                d.count = 10'(total);
                d.last = 1'b1;
                descriptor_q.push_back(d);
                n_reads++;
                return;
            end

            // A write is cut at every page boundary.
            n_writes++;
            done = 0;
            while (done < total) begin
                a   = start + done;
                off = a & (page - 1);
                n   = (off + (total - done) <= page) ? total - done : page - off;
                done += n;
                d.kind = KIND_WRITE;
                d.opcode = OP_WRITE | ((cap == 512 && a[8]) ? OP_A8 : 8'h00);
                d.addr_bytes = 2'(nab);
                d.addr = 24'(a) & amask;
                d.count = 10'(n);
                d.last = (done >= total);
                descriptor_q.push_back(d);
            end
        endfunction

        task check_result(t_descriptor got);
            t_descriptor want;
            n_results++;
            if (descriptor_q.size() == 0) begin
                report($sformatf("descriptor with nothing outstanding: kind %s addr %h",
                                 got.kind.name(), got.addr));
                return;
            end
            want = descriptor_q.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %s, expected %s", got.kind.name(), want.kind.name()));
            if (got.opcode !== want.opcode)
                report($sformatf("opcode %h, expected %h", got.opcode, want.opcode));
            if (got.addr_bytes !== want.addr_bytes)
                report($sformatf("address bytes %0d, expected %0d",
                                 got.addr_bytes, want.addr_bytes));
            if (got.addr !== want.addr)
                report($sformatf("address %h, expected %h", got.addr, want.addr));
            if (got.count !== want.count)
                report($sformatf("byte count %0d, expected %0d", got.count, want.count));
            if (got.last !== want.last)
                report($sformatf("last %b, expected %b", got.last, want.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [4:0]  i_cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    planner_scoreboard sb;
    int     cycle_count = 0;
    int     burst_left  = 0;
    int     n_settings  = 0;
    int     hold_req    = 0;
    int     hold_seen   = 0;
    int     hold_left   = 0;
    int     mode_left   = 0;
    int     stall_tick  = 0;
    t_stall stall_mode  = STALL_NONE;

    spi_eeprom_transfer_planner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // Clock with a period of 10.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d descriptors outstanding.",
                     cycle_count, sb.descriptor_q.size());
            $display("spi_eeprom_transfer_planner_tb NOT OK");
            $finish;
        end
    end

    // Descriptor receiver: a long hold-off on request, otherwise a rotating stall pattern.
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall'($urandom_range(0, 3));
                mode_left  = $urandom_range(16, 96);
            end
            mode_left--;
            stall_tick++;
            case (stall_mode)
                STALL_NONE:     m_tready = 1'b1;
                STALL_RANDOM:   m_tready = 1'($urandom_range(0, 1));
                STALL_SPARSE:   m_tready = ($urandom_range(0, 7) != 0);
                STALL_PERIODIC: m_tready = ((stall_tick % 5) < 3);
                default:        m_tready = 1'b1;
            endcase
        end
    end

    // Sample every accepted descriptor.
    always @(posedge i_clk) begin : descriptor_monitor
        t_descriptor got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.kind       = t_kind'(m_tuser);
            got.opcode     = m_tdata[7:0];
            got.addr_bytes = m_tdata[9:8];
            got.addr       = m_tdata[33:10];
            got.count      = m_tdata[43:34];
            got.last       = m_tlast;
            sb.check_result(got);
        end
    end

    // All driving tasks start and end just after a falling edge.
    task automatic write_reg(input logic [1:0] index, input logic [4:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(index, value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [4:0] cap_value, input logic [4:0] page_value);
        write_reg(CFG_CAPACITY, cap_value);
        write_reg(CFG_PAGE_SIZE, page_value);
        n_settings++;
    endtask

    // Offer one request; requests go out in bursts with random gaps in between.
    task automatic push_request(input logic cmd, input logic [23:0] start,
                                input logic [9:0] req_len);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) :
                  ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {6'd0, req_len, start};
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(cmd, start, req_len);
        burst_left--;
        @(negedge i_clk);
    endtask

    // Mostly in-range requests, with clipping, out-of-range, empty and oversized ones mixed in.
    task automatic random_requests(input int count);
        longint cap, page;
        logic cmd;
        logic [23:0] start;
        logic [9:0] req_len;
        int pick;
        repeat (count) begin
            cap   = sb.capacity_bytes();
            page  = sb.page_bytes();
            pick  = $urandom_range(0, 99);
            cmd   = ($urandom_range(0, 99) < 60) ? CMD_WRITE : CMD_READ;
            start = 24'($urandom_range(0, 32'(cap - 1)));
            req_len = 10'($urandom_range(1, $urandom_range(0, 1) ? 512 : 32'(2 * page)));
            if (pick < 12) begin
                if (cap > 600)
                    start = 24'(cap - $urandom_range(1, 600));
            end else if (pick < 20) begin
                if (cap < (longint'(1) << 24))
                    start = 24'($urandom_range(32'(cap), 32'hFFFFFF));
                else
                    req_len = 10'd0;
            end else if (pick < 26) begin
                req_len = 10'd0;
            end else if (pick < 32) begin
                req_len = 10'($urandom_range(513, 1023));
            end
            push_request(cmd, start, req_len);
        end
    endtask

    // Stop offering and wait until every planned descriptor has come out.
    task automatic drain();
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (sb.descriptor_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        sb = new();
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CAPACITY;
        i_cfg_data  = 5'd0;
        s_tvalid    = 1'b0;
        s_tdata     = 40'd0;
        s_tuser     = CMD_READ;
        m_tready    = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset settings: 32 KiB part with 64-byte pages.
        n_settings++;
        push_request(CMD_READ,  24'd0, 10'd1);
        push_request(CMD_WRITE, 24'd0, 10'd1);
        push_request(CMD_READ,  24'd100, 10'd0);
        push_request(CMD_WRITE, 24'd100, 10'd0);
        push_request(CMD_READ,  24'hFFFFFF, 10'd5);
        push_request(CMD_WRITE, 24'd32768, 10'd1);
        push_request(CMD_READ,  24'd32767, 10'd512);
        push_request(CMD_WRITE, 24'd32758, 10'd100);
        push_request(CMD_READ,  24'd0, 10'd512);
        push_request(CMD_READ,  24'd100, 10'd1023);
        push_request(CMD_WRITE, 24'd0, 10'd512);
        push_request(CMD_WRITE, 24'd63, 10'd2);
        push_request(CMD_WRITE, 24'd1, 10'd1023);
        push_request(CMD_WRITE, 24'hFFFFFF, 10'd1023);
        random_requests(16);
        drain();

        // 512-byte part: address bit 8 travels in the opcode.
        set_config(5'd9, 5'd4);
        push_request(CMD_READ,  24'h000100, 10'd3);
        push_request(CMD_READ,  24'h0000FF, 10'd2);
        push_request(CMD_WRITE, 24'h0000F8, 10'd32);
        push_request(CMD_WRITE, 24'h000000, 10'd512);
        push_request(CMD_WRITE, 24'h0001FF, 10'd1);
        push_request(CMD_READ,  24'h000200, 10'd1);
        random_requests(16);
        drain();

        // Smallest pages on a large part: a misaligned write touches 33 pages.
        set_config(5'd20, 5'd4);
        push_request(CMD_WRITE, 24'd8, 10'd512);
        push_request(CMD_WRITE, 24'h0FFFF8, 10'd16);
        random_requests(16);
        drain();

        // Largest part and largest pages.
        set_config(5'd24, 5'd9);
        push_request(CMD_WRITE, 24'hFFFFFF, 10'd512);
        push_request(CMD_READ,  24'hFFFE00, 10'd1023);
        random_requests(16);
        drain();

        // Both registers below range; the spare indexes are written too.
        set_config(5'd0, 5'd0);
        write_reg(CFG_SPARE_2, 5'($urandom_range(0, 31)));
        write_reg(CFG_SPARE_3, 5'($urandom_range(0, 31)));
        push_request(CMD_WRITE, 24'd127, 10'd512);
        push_request(CMD_READ,  24'd0, 10'd128);
        random_requests(16);
        drain();

        // Both registers above range.
        set_config(5'd31, 5'd15);
        random_requests(16);
        drain();

        // Two address bytes at the 64 KiB limit, then three just past it.
        set_config(5'd16, 5'd5);
        random_requests(16);
        drain();
        set_config(5'd17, 5'd8);
        random_requests(16);
        drain();

        // Long receiver hold-off under page-heavy writes so the input backs up.
        set_config(5'd15, 5'd4);
        hold_req++;
        repeat (12) push_request(CMD_WRITE, 24'($urandom_range(0, 32767)), 10'd512);
        drain();

        // Random settings.
        repeat (4) begin
            set_config(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            random_requests(12);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d requests (%0d reads, %0d writes, %0d rejected), %0d descriptors.",
                 sb.n_reads + sb.n_writes + sb.n_rejects, sb.n_reads, sb.n_writes,
                 sb.n_rejects, sb.n_results);
        $display("Used %0d register settings including both saturating extremes.", n_settings);
        if (sb.n_errors == 0) begin
            $display("spi_eeprom_transfer_planner_tb OK");
        end else begin
            $display("%0d mismatches.", sb.n_errors);
            $display("spi_eeprom_transfer_planner_tb NOT OK");
        end
        $finish;
    end

endmodule
